// ----- rtl/sliding_window_peak_event_count_defines.svh -----
// Assertion helpers for the RTL files; only swpec_dp includes them.
// Each macro expects clk and rst_n in scope.
`ifndef SLIDING_WINDOW_PEAK_EVENT_COUNT_DEFINES_SVH
`define SLIDING_WINDOW_PEAK_EVENT_COUNT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SWPEC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("swpec assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SWPEC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("swpec assertion failed");

`endif

// ----- rtl/swpec_pkg.sv -----
package swpec_pkg;

    localparam int RING_DEPTH = 1024;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int CNT_W      = $clog2(RING_DEPTH + 1);
    localparam int STAMP_W    = 32;
    localparam int OUT_CNT_W  = 11;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;

    localparam logic [STAMP_W-1:0] WINDOW_RESET = 32'd60;

    // Register indexes, taken from paddr[ADDR_W-1:2].
    localparam logic REG_WINDOW = 1'b0;

    typedef struct packed {
        logic load;
        logic drop;
        logic set_ovf;
        logic push;
    } swpec_cmd_t;

    typedef struct packed {
        logic cnt_zero;
        logic span_over;
        logic full;
        logic out_busy;
    } swpec_sts_t;

endpackage

// ----- rtl/swpec_regs.sv -----
module swpec_regs
    import swpec_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    output logic [STAMP_W-1:0]  window_seconds
);

    logic [STAMP_W-1:0] window_reg;
    logic [STAMP_W-1:0] window_next;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[ADDR_W-1] == REG_WINDOW);

    always_comb
    begin
        window_next = window_reg;
        if (wr_en)
        begin
            window_next = pwdata[STAMP_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_RESET;
        end
        else
        begin
            window_reg <= window_next;
        end
    end

    always_comb
    begin
        unique case (paddr[ADDR_W-1])
            REG_WINDOW: prdata = DATA_W'(window_reg);
            default:    prdata = '0;
        endcase
    end

    assign window_seconds = window_reg;

endmodule

// ----- rtl/swpec_ctrl.sv -----
module swpec_ctrl
    import swpec_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        event_valid,
    output logic        event_stall,
    input  swpec_sts_t  sts,
    output swpec_cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_POP  = 2'd1;
    localparam logic [1:0] ST_PUSH = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (event_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_POP;
                end
            end
            ST_POP:
            begin
                if (!sts.cnt_zero && sts.span_over)
                begin
                    cmd.drop = 1'b1;
                end
                else if (sts.full)
                begin
                    // The new oldest entry has to be read before the push.
                    cmd.drop    = 1'b1;
                    cmd.set_ovf = 1'b1;
                    state_next  = ST_PUSH;
                end
                else if (!sts.out_busy)
                begin
                    cmd.push   = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (!sts.out_busy)
                begin
                    cmd.push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign event_stall = (state_reg != ST_IDLE);

endmodule

// ----- rtl/swpec_dp.sv -----
`include "sliding_window_peak_event_count_defines.svh"

module swpec_dp
    import swpec_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  swpec_cmd_t            cmd,
    output swpec_sts_t            sts,
    input  logic [STAMP_W-1:0]    event_time,
    input  logic [STAMP_W-1:0]    window_seconds,
    output logic                  result_valid,
    input  logic                  result_stall,
    output logic [OUT_CNT_W-1:0]  window_count,
    output logic [OUT_CNT_W-1:0]  best_count,
    output logic [STAMP_W-1:0]    best_start,
    output logic [STAMP_W-1:0]    best_end,
    output logic                  overflow,
    output logic                  out_of_order
);

    logic [STAMP_W-1:0] ring_mem [RING_DEPTH];
    logic [STAMP_W-1:0] rd_reg;

    logic [PTR_W-1:0]   ptr_reg,   ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [STAMP_W-1:0] last_reg;
    logic [STAMP_W-1:0] t_reg;
    logic               ooo_reg;
    logic               ovf_reg;
    logic [CNT_W-1:0]   peak_cnt_reg;
    logic [STAMP_W-1:0] peak_first_reg;
    logic [STAMP_W-1:0] peak_last_reg;
    logic               out_valid_reg;
    logic [CNT_W-1:0]   out_cnt_reg;
    logic               out_ovf_reg;
    logic               out_ooo_reg;

    logic [CNT_W:0]     slot_sum;
    logic [PTR_W-1:0]   slot;
    logic [STAMP_W-1:0] oldest;
    logic [CNT_W-1:0]   push_cnt;

    // Stored stamps never exceed t_reg, so the span cannot wrap.
    assign sts.cnt_zero  = (count_reg == '0);
    assign sts.span_over = ((t_reg - rd_reg) > window_seconds);
    assign sts.full      = (count_reg == CNT_W'(RING_DEPTH));
    assign sts.out_busy  = out_valid_reg && result_stall;

    always_comb
    begin
        ptr_next   = ptr_reg;
        count_next = count_reg;
        if (cmd.drop)
        begin
            if (ptr_reg == PTR_W'(RING_DEPTH - 1))
            begin
                ptr_next = '0;
            end
            else
            begin
                ptr_next = ptr_reg + PTR_W'(1);
            end
            count_next = count_reg - CNT_W'(1);
        end
        else if (cmd.push)
        begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        slot_sum = (CNT_W + 1)'(ptr_reg) + (CNT_W + 1)'(count_reg);
        if (slot_sum >= (CNT_W + 1)'(RING_DEPTH))
        begin
            slot_sum = slot_sum - (CNT_W + 1)'(RING_DEPTH);
        end
        slot = slot_sum[PTR_W-1:0];
    end

    // An empty ring means the new stamp is its own window start.
    assign oldest   = (count_reg == '0) ? t_reg : rd_reg;
    assign push_cnt = count_reg + CNT_W'(1);

    // The read port follows the next oldest pointer, so rd_reg holds the
    // oldest stored stamp in the cycle after any pointer move.
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            ring_mem[slot] <= t_reg;
        end
        rd_reg <= ring_mem[ptr_next];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            if (event_time < last_reg)
            begin
                t_reg   <= last_reg;
                ooo_reg <= 1'b1;
            end
            else
            begin
                t_reg   <= event_time;
                ooo_reg <= 1'b0;
            end
        end
        if (cmd.load)
        begin
            ovf_reg <= 1'b0;
        end
        else if (cmd.set_ovf)
        begin
            ovf_reg <= 1'b1;
        end
        if (cmd.push)
        begin
            out_cnt_reg <= push_cnt;
            out_ovf_reg <= ovf_reg;
            out_ooo_reg <= ooo_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg        <= '0;
            count_reg      <= '0;
            last_reg       <= '0;
            peak_cnt_reg   <= '0;
            peak_first_reg <= '0;
            peak_last_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            ptr_reg   <= ptr_next;
            count_reg <= count_next;
            if (cmd.push)
            begin
                last_reg <= t_reg;
                if (push_cnt > peak_cnt_reg)
                begin
                    peak_cnt_reg   <= push_cnt;
                    peak_first_reg <= oldest;
                    peak_last_reg  <= t_reg;
                end
            end
            if (cmd.push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign window_count = OUT_CNT_W'(out_cnt_reg);
    assign best_count   = OUT_CNT_W'(peak_cnt_reg);
    assign best_start   = peak_first_reg;
    assign best_end     = peak_last_reg;
    assign overflow     = out_ovf_reg;
    assign out_of_order = out_ooo_reg;

    `SWPEC_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CNT_W'(RING_DEPTH))
    `SWPEC_ASSERT_SAME(a_push_free, cmd.push, !(out_valid_reg && result_stall))
    `SWPEC_ASSERT_SAME(a_drop_nonempty, cmd.drop, count_reg != '0)
    `SWPEC_ASSERT_NEXT(a_push_result, cmd.push, out_valid_reg && (count_reg != '0))

endmodule

// ----- rtl/sliding_window_peak_event_count.sv -----
// Channel    Direction  Handshake                      Payload
// event      in         event_valid / event_stall      event_time
// result     out        result_valid / result_stall    window_count, best_count,
//                                                      best_start, best_end,
//                                                      overflow, out_of_order
// config     in         APB (psel, penable, pready)    window_seconds at byte 0
//
// An event is loaded, then each stamp that has left the window is dropped and the
// new stamp is pushed; when the ring is full, its oldest is dropped before the push.
// The pace of the drops is set by the single read port of the stamp ring, which reads
// one oldest stamp per cycle for the span check.
// Reset clears the pointers, counts and best window; the ring needs no clearing.
// A stalled result holds; the next event is taken meanwhile and waits to push.
module sliding_window_peak_event_count
    import swpec_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [DATA_W-1:0]     pwdata,
    output logic [DATA_W-1:0]     prdata,
    output logic                  pready,
    input  logic                  event_valid,
    output logic                  event_stall,
    input  logic [STAMP_W-1:0]    event_time,
    output logic                  result_valid,
    input  logic                  result_stall,
    output logic [OUT_CNT_W-1:0]  window_count,
    output logic [OUT_CNT_W-1:0]  best_count,
    output logic [STAMP_W-1:0]    best_start,
    output logic [STAMP_W-1:0]    best_end,
    output logic                  overflow,
    output logic                  out_of_order
);

    logic [STAMP_W-1:0] window_seconds;
    swpec_cmd_t         cmd;
    swpec_sts_t         sts;

    swpec_regs u_regs (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .window_seconds (window_seconds)
    );

    swpec_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .event_valid (event_valid),
        .event_stall (event_stall),
        .sts         (sts),
        .cmd         (cmd)
    );

    swpec_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .event_time     (event_time),
        .window_seconds (window_seconds),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .window_count   (window_count),
        .best_count     (best_count),
        .best_start     (best_start),
        .best_end       (best_end),
        .overflow       (overflow),
        .out_of_order   (out_of_order)
    );

endmodule
